// ===== sv/ppes_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the point pair error statistics block
package ppes_pkg;

    // defaults for the top level parameters
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_PAIRS_DEF  = 65536;

    // field widths of the result transaction and the pair counter
    localparam int DIFF_BITS  = 17;
    localparam int SQR_BITS   = 34;
    localparam int TOTAL_BITS = 50;
    localparam int COUNT_BITS = 17;

    // sequencing
    localparam int NUM_AXES  = 3;
    localparam int STEP_BITS = $clog2(TOTAL_BITS);

    // result tdata layout, lowest field first
    localparam int OFF_DIFF_X = 0;
    localparam int OFF_DIFF_Y = OFF_DIFF_X + DIFF_BITS;
    localparam int OFF_DIFF_Z = OFF_DIFF_Y + DIFF_BITS;
    localparam int OFF_SQR    = OFF_DIFF_Z + DIFF_BITS;
    localparam int OFF_TOTAL  = OFF_SQR + SQR_BITS;
    localparam int OFF_MEAN   = OFF_TOTAL + TOTAL_BITS;
    localparam int OFF_MIN    = OFF_MEAN + SQR_BITS;
    localparam int OFF_MAX    = OFF_MIN + SQR_BITS;
    localparam int M_FIELD_BITS = OFF_MAX + SQR_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // saturation limits
    localparam logic [SQR_BITS-1:0]   SQR_MAX   = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       add_en;
        logic [1:0] axis;
        logic       update;
        logic       div_step;
        logic       write;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

endpackage

// ===== sv/ppes_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine sequencing squaring, update, division and output
module ppes_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ppes_pkg::status_t stat,
    output ppes_pkg::cmd_t    cmd
);

    ppes_pkg::state_t                 state_reg, state_next;
    logic [ppes_pkg::STEP_BITS-1:0]   cnt_reg, cnt_next;

    // state and step counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppes_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ppes_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid)
                begin
                    state_next = ppes_pkg::ST_SQUARE;
                end
            end
            ppes_pkg::ST_SQUARE:
            begin
                if (cnt_reg == ppes_pkg::STEP_BITS'(ppes_pkg::NUM_AXES))
                begin
                    state_next = ppes_pkg::ST_UPDATE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ppes_pkg::ST_UPDATE:
            begin
                cnt_next = '0;
                if (stat.last)
                begin
                    state_next = ppes_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = ppes_pkg::ST_WRITE;
                end
            end
            ppes_pkg::ST_DIVIDE:
            begin
                if (cnt_reg == ppes_pkg::STEP_BITS'(ppes_pkg::TOTAL_BITS - 1))
                begin
                    state_next = ppes_pkg::ST_WRITE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ppes_pkg::ST_WRITE:
            begin
                if (stat.out_free)
                begin
                    state_next = ppes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppes_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ppes_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ppes_pkg::ST_SQUARE:
            begin
                cmd.axis   = cnt_reg[1:0];
                cmd.mul_en = (cnt_reg != ppes_pkg::STEP_BITS'(ppes_pkg::NUM_AXES));
                cmd.add_en = (cnt_reg != '0);
            end
            ppes_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ppes_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ppes_pkg::ST_WRITE:
            begin
                cmd.write = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/ppes_datapath.sv =====
`timescale 1ns / 1ps
// datapath: differences, shared squarer, statistics, serial divider, output register
module ppes_datapath
#(
    parameter int COORD_BITS   = ppes_pkg::COORD_BITS_DEF,
    parameter int MAX_PAIRS    = ppes_pkg::MAX_PAIRS_DEF,
    parameter int S_TDATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [S_TDATA_BITS-1:0]           s_tdata,
    input  logic                              s_tlast,
    input  ppes_pkg::cmd_t                    cmd,
    output ppes_pkg::status_t                 stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppes_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                              m_tuser
);

    localparam int DW       = COORD_BITS + 1;
    localparam int PW       = 2 * DW;
    localparam int SUM_BITS = (PW + 2 > ppes_pkg::SQR_BITS + 1) ? PW + 2 : ppes_pkg::SQR_BITS + 1;
    localparam int SB       = ppes_pkg::SQR_BITS;
    localparam int TB       = ppes_pkg::TOTAL_BITS;
    localparam int CB       = ppes_pkg::COUNT_BITS;
    localparam longint COUNT_FIELD_MAX = (64'd1 << CB) - 1;
    localparam longint COUNT_CAP_L     = (longint'(MAX_PAIRS) < COUNT_FIELD_MAX) ?
                                         longint'(MAX_PAIRS) : COUNT_FIELD_MAX;
    localparam logic [CB-1:0] COUNT_CAP = CB'(COUNT_CAP_L);

    // working registers
    logic signed [DW-1:0]      diff_reg [ppes_pkg::NUM_AXES];
    logic signed [PW-1:0]      prod_reg;
    logic [SUM_BITS-1:0]       sum_reg;
    logic [SB-1:0]             sq_reg;
    logic                      last_reg;

    // statistics
    logic [TB-1:0]             total_reg, total_next;
    logic [CB-1:0]             count_reg, count_next;
    logic [SB-1:0]             min_reg, min_next;
    logic [SB-1:0]             max_reg, max_next;

    // set results and divider
    logic [TB-1:0]             res_total_reg;
    logic [SB-1:0]             res_min_reg;
    logic [SB-1:0]             res_max_reg;
    logic [CB-1:0]             divisor_reg;
    logic [TB-1:0]             quo_reg;
    logic [CB-1:0]             rem_reg;

    // output register
    logic                              out_valid_reg;
    logic [ppes_pkg::M_TDATA_BITS-1:0] out_data_reg;
    logic                              out_done_reg;

    logic signed [COORD_BITS-1:0] first_c  [ppes_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] second_c [ppes_pkg::NUM_AXES];
    logic signed [DW-1:0]         mul_op;
    logic [SB-1:0]                sq_sat;
    logic [TB:0]                  total_sum;
    logic [CB:0]                  rem_shift;
    logic                         rem_ge;
    logic [SB-1:0]                mean_val;
    logic [ppes_pkg::M_FIELD_BITS-1:0] fields;

    // unpack coordinates, first point in the low fields
    always_comb
    begin
        for (int a = 0; a < ppes_pkg::NUM_AXES; a++)
        begin
            first_c[a]  = s_tdata[a*COORD_BITS +: COORD_BITS];
            second_c[a] = s_tdata[(a+ppes_pkg::NUM_AXES)*COORD_BITS +: COORD_BITS];
        end
    end

    // squarer operand select
    always_comb
    begin
        case (cmd.axis)
            2'd0:    mul_op = diff_reg[0];
            2'd1:    mul_op = diff_reg[1];
            default: mul_op = diff_reg[2];
        endcase
    end

    // squared distance saturation and running statistics
    always_comb
    begin
        sq_sat     = (sum_reg > SUM_BITS'(ppes_pkg::SQR_MAX)) ? ppes_pkg::SQR_MAX
                                                               : sum_reg[SB-1:0];
        total_sum  = {1'b0, total_reg} + (TB+1)'(sq_sat);
        total_next = total_sum[TB] ? ppes_pkg::TOTAL_MAX : total_sum[TB-1:0];
        count_next = (count_reg < COUNT_CAP) ? count_reg + 1'b1 : count_reg;
        min_next   = (sq_sat < min_reg) ? sq_sat : min_reg;
        max_next   = (sq_sat > max_reg) ? sq_sat : max_reg;
    end

    // restoring division step and mean saturation
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[TB-1]};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
        if (quo_reg > TB'(ppes_pkg::SQR_MAX))
        begin
            mean_val = ppes_pkg::SQR_MAX;
        end
        else
        begin
            mean_val = quo_reg[SB-1:0];
        end
    end

    // pack the result transaction
    always_comb
    begin
        fields = '0;
        fields[ppes_pkg::OFF_DIFF_X +: ppes_pkg::DIFF_BITS] = ppes_pkg::DIFF_BITS'(diff_reg[0]);
        fields[ppes_pkg::OFF_DIFF_Y +: ppes_pkg::DIFF_BITS] = ppes_pkg::DIFF_BITS'(diff_reg[1]);
        fields[ppes_pkg::OFF_DIFF_Z +: ppes_pkg::DIFF_BITS] = ppes_pkg::DIFF_BITS'(diff_reg[2]);
        fields[ppes_pkg::OFF_SQR +: SB] = sq_reg;
        if (last_reg)
        begin
            fields[ppes_pkg::OFF_TOTAL +: TB] = res_total_reg;
            fields[ppes_pkg::OFF_MEAN +: SB]  = mean_val;
            fields[ppes_pkg::OFF_MIN +: SB]   = res_min_reg;
            fields[ppes_pkg::OFF_MAX +: SB]   = res_max_reg;
        end
    end

    // differences, squarer and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < ppes_pkg::NUM_AXES; a++)
            begin
                diff_reg[a] <= DW'(second_c[a]) - DW'(first_c[a]);
            end
            sum_reg <= '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_op * mul_op;
        end
        if (cmd.add_en)
        begin
            sum_reg <= sum_reg + SUM_BITS'(unsigned'(prod_reg));
        end
        if (cmd.update)
        begin
            sq_reg <= sq_sat;
        end
    end

    // set snapshot and serial divider
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_total_reg <= total_next;
            res_min_reg   <= min_next;
            res_max_reg   <= max_next;
            divisor_reg   <= count_next;
            quo_reg       <= total_next;
            rem_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[TB-2:0], rem_ge};
            rem_reg <= rem_ge ? CB'(rem_shift - {1'b0, divisor_reg}) : rem_shift[CB-1:0];
        end
    end

    // running statistics, cleared after the last pair of a set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            count_reg <= '0;
            min_reg   <= ppes_pkg::SQR_MAX;
            max_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg <= s_tlast;
            end
            if (cmd.update)
            begin
                if (last_reg)
                begin
                    total_reg <= '0;
                    count_reg <= '0;
                    min_reg   <= ppes_pkg::SQR_MAX;
                    max_reg   <= '0;
                end
                else
                begin
                    total_reg <= total_next;
                    count_reg <= count_next;
                    min_reg   <= min_next;
                    max_reg   <= max_next;
                end
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            out_data_reg <= ppes_pkg::M_TDATA_BITS'(fields);
            out_done_reg <= last_reg;
        end
    end

    assign stat.last     = last_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_done_reg;

endmodule

// ===== sv/point_pair_error_stats.sv =====
`timescale 1ns / 1ps
// top level of the point pair error statistics block
// per pair: load, square and sum the axes, update the statistics, write the result;
// the last pair of a set divides out the mean before its write; one squarer is shared
//   over three axes, and the divider gives one bit per cycle over the 50 bit total
// one pair is in work at a time; the output register holds a result while the next pair runs
// reset: rst_n clears the controller, the running statistics and the output valid
module point_pair_error_stats
#(
    parameter int MAX_PAIRS  = ppes_pkg::MAX_PAIRS_DEF,
    parameter int COORD_BITS = ppes_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [S_TDATA_BITS-1:0]           s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // diff_x, diff_y, diff_z, sqr_dist, total_sqr, mean_sqr, min_sqr, max_sqr
    output logic [ppes_pkg::M_TDATA_BITS-1:0] m_tdata,
    // set_done
    output logic                              m_tuser
);

    ppes_pkg::cmd_t    cmd;
    ppes_pkg::status_t stat;

    // controller
    ppes_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    ppes_datapath
    #(
        .COORD_BITS   (COORD_BITS),
        .MAX_PAIRS    (MAX_PAIRS),
        .S_TDATA_BITS (S_TDATA_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sv/ppes_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the point pair error statistics block
module ppes_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ppes_pkg::M_TDATA_BITS-1:0] m_tdata,
    input logic                              m_tuser
);

    localparam int SB = ppes_pkg::SQR_BITS;

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one pair in work at a time
    a_one_pair: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pair is in work");

    // statistics fields are zero outside a finished set
    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            m_tdata[ppes_pkg::M_FIELD_BITS-1:ppes_pkg::OFF_TOTAL] == '0)
        else $error("statistics fields not zero on a pair inside a set");

    // minimum never above maximum on a finished set
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            m_tdata[ppes_pkg::OFF_MIN +: SB] <= m_tdata[ppes_pkg::OFF_MAX +: SB])
        else $error("set minimum above set maximum");

endmodule

bind point_pair_error_stats ppes_checker u_ppes_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
